### src/bridge_csr_register_block_core_macros.svh
// assertion macros for the host-bridge csr block
// no dependencies; taken in by the core with `include
`ifndef BRIDGE_CSR_REGISTER_BLOCK_CORE_MACROS_SVH
`define BRIDGE_CSR_REGISTER_BLOCK_CORE_MACROS_SVH

// checked outside reset
`define BCRB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define BCRB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/bcrb_pkg.sv
// shared types, constants and decode tables of the host-bridge csr block
// no dependencies
package bcrb_pkg;

   localparam int MEM_DEPTH = 30;
   localparam int SLOT_W = $clog2(MEM_DEPTH);

   // configuration register indexes
   localparam logic [2:0] CSR_VENDOR_ID     = 3'd0;
   localparam logic [2:0] CSR_DEVICE_ID     = 3'd1;
   localparam logic [2:0] CSR_PCI_STATUS    = 3'd2;
   localparam logic [2:0] CSR_REVISION_ID   = 3'd3;
   localparam logic [2:0] CSR_CLASS_CODE    = 3'd4;
   localparam logic [2:0] CSR_CAP_OFFSET    = 3'd5;
   localparam logic [2:0] CSR_AGP_CAP_WORD  = 3'd6;
   localparam logic [2:0] CSR_AGP_CMD_WRITE = 3'd7;

   // opcodes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // kinds of word decode
   localparam logic [2:0] KD_NONE     = 3'd0;
   localparam logic [2:0] KD_MEM      = 3'd1;
   localparam logic [2:0] KD_IDENT0   = 3'd2;
   localparam logic [2:0] KD_IDENT8   = 3'd3;
   localparam logic [2:0] KD_CAP      = 3'd4;
   localparam logic [2:0] KD_AGP_CAP  = 3'd5;
   localparam logic [2:0] KD_CFG_DATA = 3'd6;
   localparam logic [2:0] KD_CLOCK    = 3'd7;

   // memory slots
   localparam logic [SLOT_W-1:0] SL_CFG_ADDR = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SL_BUS_NUM  = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SL_AGP_CMD  = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] SL_ARB      = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] SL_SIC      = SLOT_W'(4);
   localparam logic [SLOT_W-1:0] SL_ROPE     = SLOT_W'(5);
   localparam logic [SLOT_W-1:0] SL_BUS_MODE = SLOT_W'(6);
   localparam logic [SLOT_W-1:0] SL_WIN0     = SLOT_W'(7);
   localparam logic [SLOT_W-1:0] SL_ERR0     = SLOT_W'(20);

   localparam logic [63:0] CFG_ADDR_WRITE = 64'h0000_0000_00ff_fffc;
   localparam logic [63:0] ARB_WRITE      = 64'h0000_0000_0000_007f;
   localparam logic [63:0] ARB_LOCKED     = 64'h0000_0000_0000_0040;
   localparam logic [63:0] SIC_MASK       = 64'h0000_0000_0000_0078;
   localparam logic [63:0] SIC_HANDSHAKE  = 64'h0000_0000_0000_0030;
   localparam int          SIC_CL_BIT     = 4;
   localparam int          SIC_CE_BIT     = 5;
   localparam logic [63:0] ROPE_SINGLE    = 64'h0000_0000_0000_0100;
   localparam logic [63:0] CLOCK_LOCKED   = 64'h0000_0000_0000_0008;
   localparam logic [63:0] BUS_MODE_WRITE = 64'h0000_0000_0001_0100;
   localparam logic [63:0] BUS_NUM_WRITE  = 64'h0000_0000_0000_ffff;
   localparam logic [63:0] WIN_BASE_RESET = 64'h0000_0000_8000_0000;

   typedef struct packed {
      logic [2:0]        kind;
      logic [SLOT_W-1:0] slot;
   } dec_type;

   function automatic dec_type decode(input logic [7:0] word);
      dec_type d;
      d.kind = KD_MEM;
      d.slot = SL_CFG_ADDR;
      case ({word, 3'b000})
         11'h000: d.kind = KD_IDENT0;
         11'h008: d.kind = KD_IDENT8;
         11'h030: d.kind = KD_CAP;
         11'h048: d.kind = KD_CFG_DATA;
         11'h060: d.kind = KD_AGP_CAP;
         11'h618: d.kind = KD_CLOCK;
         11'h040: d.slot = SL_CFG_ADDR;
         11'h058: d.slot = SL_BUS_NUM;
         11'h068: d.slot = SL_AGP_CMD;
         11'h080: d.slot = SL_ARB;
         11'h108: d.slot = SL_SIC;
         11'h610: d.slot = SL_ROPE;
         11'h620: d.slot = SL_BUS_MODE;
         11'h200: d.slot = SL_WIN0;
         11'h208: d.slot = SL_WIN0 + SLOT_W'(1);
         11'h210: d.slot = SL_WIN0 + SLOT_W'(2);
         11'h218: d.slot = SL_WIN0 + SLOT_W'(3);
         11'h220: d.slot = SL_WIN0 + SLOT_W'(4);
         11'h228: d.slot = SL_WIN0 + SLOT_W'(5);
         11'h230: d.slot = SL_WIN0 + SLOT_W'(6);
         11'h238: d.slot = SL_WIN0 + SLOT_W'(7);
         11'h250: d.slot = SL_WIN0 + SLOT_W'(8);
         11'h258: d.slot = SL_WIN0 + SLOT_W'(9);
         11'h278: d.slot = SL_WIN0 + SLOT_W'(10);
         11'h280: d.slot = SL_WIN0 + SLOT_W'(11);
         11'h288: d.slot = SL_WIN0 + SLOT_W'(12);
         11'h680: d.slot = SL_ERR0;
         11'h688: d.slot = SL_ERR0 + SLOT_W'(1);
         11'h690: d.slot = SL_ERR0 + SLOT_W'(2);
         11'h6a0: d.slot = SL_ERR0 + SLOT_W'(3);
         11'h0a0: d.slot = SL_ERR0 + SLOT_W'(4);
         11'h600: d.slot = SL_ERR0 + SLOT_W'(5);
         11'h290: d.slot = SL_ERR0 + SLOT_W'(6);
         11'h298: d.slot = SL_ERR0 + SLOT_W'(7);
         11'h2a0: d.slot = SL_ERR0 + SLOT_W'(8);
         11'h070: d.slot = SL_ERR0 + SLOT_W'(9);
         default: d.kind = KD_NONE;
      endcase
      return d;
   endfunction

   function automatic logic [63:0] slot_reset(input logic [SLOT_W-1:0] slot);
      logic [63:0] v;
      case (slot)
         SL_ARB, SL_BUS_MODE:          v = 64'h1;
         SL_WIN0, SL_WIN0 + SLOT_W'(1),
         SL_WIN0 + SLOT_W'(4), SL_WIN0 + SLOT_W'(5),
         SL_WIN0 + SLOT_W'(8), SL_WIN0 + SLOT_W'(9): v = WIN_BASE_RESET;
         SL_WIN0 + SLOT_W'(10):        v = 64'h0000_0000_0000_0006;
         SL_WIN0 + SLOT_W'(11):        v = 64'h0000_0000_fee0_0001;
         SL_WIN0 + SLOT_W'(12):        v = 64'h0000_0fff_fff0_0000;
         default:                      v = '0;
      endcase
      return v;
   endfunction

   // writable masks; the agp command mask comes from configuration instead
   function automatic logic [63:0] slot_mask(input logic [SLOT_W-1:0] slot);
      logic [63:0] m;
      case (slot)
         SL_CFG_ADDR:           m = CFG_ADDR_WRITE;
         SL_BUS_NUM:            m = BUS_NUM_WRITE;
         // bus-mode bit 3 can never be set, so arbitration bit 6 stays locked
         SL_ARB:                m = ARB_WRITE & ~ARB_LOCKED;
         SL_SIC:                m = SIC_MASK;
         SL_ROPE:               m = ~ROPE_SINGLE;
         SL_BUS_MODE:           m = BUS_MODE_WRITE;
         SL_WIN0:               m = 64'h0000_0000_7fff_0001;
         SL_WIN0 + SLOT_W'(1):  m = 64'h0000_0000_7fff_0000;
         SL_WIN0 + SLOT_W'(2):  m = 64'h0000_0fff_fc00_0001;
         SL_WIN0 + SLOT_W'(3):  m = 64'h0000_0fff_fc00_0000;
         SL_WIN0 + SLOT_W'(4):  m = 64'h0000_0000_7ff0_0001;
         SL_WIN0 + SLOT_W'(5):  m = 64'h0000_0000_7ff0_0000;
         SL_WIN0 + SLOT_W'(6):  m = 64'h0000_0fff_0000_0001;
         SL_WIN0 + SLOT_W'(7):  m = 64'h0000_0fff_0000_0000;
         SL_WIN0 + SLOT_W'(8):  m = 64'h0000_0000_7ff0_0001;
         SL_WIN0 + SLOT_W'(9):  m = 64'h0000_0000_7ff0_0000;
         SL_WIN0 + SLOT_W'(10): m = 64'h0000_0000_0006_200f;
         SL_WIN0 + SLOT_W'(11): m = 64'h0000_0fff_ffff_0001;
         SL_WIN0 + SLOT_W'(12): m = 64'h0000_0fff_ffff_0000;
         SL_AGP_CMD:            m = '0;
         default:               m = '1;
      endcase
      return m;
   endfunction

   function automatic logic [63:0] size_mask(input logic [3:0] n);
      logic [63:0] m;
      case (n)
         4'd1:    m = 64'h0000_0000_0000_00ff;
         4'd2:    m = 64'h0000_0000_0000_ffff;
         4'd4:    m = 64'h0000_0000_ffff_ffff;
         4'd8:    m = '1;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

### src/bcrb_req_if.sv
// request channel of the host-bridge csr block: one bus access per request
// no dependencies
interface bcrb_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [10:0] offset;
   logic [3:0]  access_size;
   logic [63:0] write_data;

   modport source (output valid, opcode, offset, access_size, write_data, input ready);
   modport sink   (input valid, opcode, offset, access_size, write_data, output ready);
endinterface

### src/bcrb_rsp_if.sv
// response channel of the host-bridge csr block
// no dependencies
interface bcrb_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] read_data;
   logic        unmodelled_access;

   modport source (output valid, read_data, unmodelled_access, input ready);
   modport sink   (input valid, read_data, unmodelled_access, output ready);
endinterface

### src/bridge_csr_register_block_core.sv
// a taken request is registered; its response is loaded into the output register once that
//    register is empty or being read. a new request is taken only after that load, as the
//    register memory is read on accept and written back when the response is loaded
// a request is taken while an earlier response still waits in the output register
// reset: synchronous, active high; clears control, identity registers and the
//    per-entry valid bits, so every register reads its reset value at once
module bridge_csr_register_block_core (
   input  logic              clock,
   input  logic              reset,
   bcrb_req_if.sink          req_if,
   bcrb_rsp_if.source        rsp_if,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic                           state_ff, state_in;
   logic                           req_accept;
   logic                           rsp_load;
   bcrb_pkg::dec_type              dec;

   logic [15:0] vendor_id_ff, device_id_ff, pci_status_ff;
   logic [7:0]  revision_id_ff, cap_offset_ff;
   logic [23:0] class_code_ff;
   logic [63:0] agp_cap_word_ff;
   logic [31:0] agp_cmd_write_ff;

   logic                           opcode_ff;
   logic [10:0]                    offset_ff;
   logic [3:0]                     size_ff;
   logic [63:0]                    wdata_ff;
   bcrb_pkg::dec_type              dec_ff;

   logic [63:0]                    mem_ram [bcrb_pkg::MEM_DEPTH];
   logic [63:0]                    mem_rdata_ff;
   logic                           rd_valid_ff;
   logic [bcrb_pkg::MEM_DEPTH-1:0] valid_ff;
   logic                           mem_we;
   logic [63:0]                    mem_wdata;

   logic [63:0] rsp_data_ff, rsp_data_in;
   logic        rsp_unmod_ff, rsp_unmod_in;
   logic        rsp_valid_ff;

   logic [2:0]  lane;
   logic [5:0]  bit_shift;
   logic [4:0]  lane_end;
   logic        size_ok;
   logic [63:0] szmask, lanes, wd_lanes, old_word, val, wmask, nv;
   logic [3:0]  cycle_size;
   logic [4:0]  cycle_end;
   logic        sic_done;

   assign dec        = bcrb_pkg::decode(req_if.offset[10:3]);
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept = req_if.valid && req_if.ready;
   assign rsp_load   = (state_ff == ST_BUSY) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in = state_ff;
      if (req_accept) begin
         state_in = ST_BUSY;
      end else if (rsp_load) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // identity and mask registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vendor_id_ff     <= '0;
         device_id_ff     <= '0;
         pci_status_ff    <= '0;
         revision_id_ff   <= '0;
         class_code_ff    <= '0;
         cap_offset_ff    <= '0;
         agp_cap_word_ff  <= '0;
         agp_cmd_write_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bcrb_pkg::CSR_VENDOR_ID:     vendor_id_ff     <= csr_wdata[15:0];
            bcrb_pkg::CSR_DEVICE_ID:     device_id_ff     <= csr_wdata[15:0];
            bcrb_pkg::CSR_PCI_STATUS:    pci_status_ff    <= csr_wdata[15:0];
            bcrb_pkg::CSR_REVISION_ID:   revision_id_ff   <= csr_wdata[7:0];
            bcrb_pkg::CSR_CLASS_CODE:    class_code_ff    <= csr_wdata[23:0];
            bcrb_pkg::CSR_CAP_OFFSET:    cap_offset_ff    <= csr_wdata[7:0];
            bcrb_pkg::CSR_AGP_CAP_WORD:  agp_cap_word_ff  <= csr_wdata;
            bcrb_pkg::CSR_AGP_CMD_WRITE: agp_cmd_write_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         opcode_ff <= req_if.opcode;
         offset_ff <= req_if.offset;
         size_ff   <= req_if.access_size;
         wdata_ff  <= req_if.write_data;
         dec_ff    <= dec;
      end
   end

   // register memory: read on accept, written back when the response is loaded
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[dec_ff.slot] <= mem_wdata;
      end
      if (req_accept) begin
         mem_rdata_ff <= mem_ram[dec.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[dec_ff.slot] <= 1'b1;
         end
         if (req_accept) begin
            rd_valid_ff <= valid_ff[dec.slot];
         end
      end
   end

   always_comb begin
      lane      = offset_ff[2:0];
      bit_shift = {lane, 3'b000};
      lane_end  = {2'b00, lane} + {1'b0, size_ff};
      size_ok   = (size_ff == 4'd1 || size_ff == 4'd2 || size_ff == 4'd4 ||
                   size_ff == 4'd8) && (lane_end <= 5'd8);
      szmask    = bcrb_pkg::size_mask(size_ff);
      lanes     = szmask << bit_shift;
      wd_lanes  = (wdata_ff << bit_shift) & lanes;
      old_word  = rd_valid_ff ? mem_rdata_ff : bcrb_pkg::slot_reset(dec_ff.slot);

      // config-data window: 8-byte cycles run as 4
      cycle_size = (size_ff == 4'd8) ? 4'd4 : size_ff;
      cycle_end  = {2'b00, lane} + {1'b0, cycle_size};

      case (dec_ff.kind)
         bcrb_pkg::KD_IDENT0:  val = {pci_status_ff, 16'h0000, device_id_ff, vendor_id_ff};
         bcrb_pkg::KD_IDENT8:  val = {32'h0, class_code_ff, revision_id_ff};
         bcrb_pkg::KD_CAP:     val = {24'h0, cap_offset_ff, 32'h0};
         bcrb_pkg::KD_AGP_CAP: val = agp_cap_word_ff;
         bcrb_pkg::KD_CLOCK:   val = bcrb_pkg::CLOCK_LOCKED;
         bcrb_pkg::KD_MEM: begin
            val = old_word;
            if (dec_ff.slot == bcrb_pkg::SL_ROPE) begin
               val = old_word | bcrb_pkg::ROPE_SINGLE;
            end
         end
         default:              val = '0;
      endcase

      wmask = bcrb_pkg::slot_mask(dec_ff.slot);
      if (dec_ff.slot == bcrb_pkg::SL_AGP_CMD) begin
         wmask = {32'h0, agp_cmd_write_ff};
      end
      nv = (old_word & ~(wmask & lanes)) | (wd_lanes & wmask);

      // error-log clear handshake
      sic_done = 1'b0;
      if (dec_ff.slot == bcrb_pkg::SL_SIC && |(lanes & bcrb_pkg::SIC_HANDSHAKE)) begin
         sic_done = nv[bcrb_pkg::SIC_CL_BIT] & old_word[bcrb_pkg::SIC_CE_BIT];
         nv[bcrb_pkg::SIC_CL_BIT] = sic_done;
         nv[bcrb_pkg::SIC_CE_BIT] = !sic_done && wd_lanes[bcrb_pkg::SIC_CE_BIT];
      end
      mem_wdata = nv;
      mem_we    = rsp_load && size_ok && (opcode_ff == bcrb_pkg::OP_WRITE) &&
                  (dec_ff.kind == bcrb_pkg::KD_MEM);

      rsp_data_in  = '0;
      rsp_unmod_in = 1'b0;
      if (size_ok) begin
         if (dec_ff.kind == bcrb_pkg::KD_CFG_DATA) begin
            if (opcode_ff == bcrb_pkg::OP_READ && cycle_end <= 5'd4) begin
               rsp_data_in = bcrb_pkg::size_mask(cycle_size);
            end
         end else begin
            rsp_unmod_in = (dec_ff.kind == bcrb_pkg::KD_NONE);
            if (opcode_ff == bcrb_pkg::OP_READ) begin
               rsp_data_in = (val >> bit_shift) & szmask;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_unmod_ff <= rsp_unmod_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.read_data         = rsp_data_ff;
   assign rsp_if.unmodelled_access = rsp_unmod_ff;

`include "bridge_csr_register_block_core_macros.svh"

   `BCRB_ASSERT(a_accept_busy, req_accept |=> state_ff == ST_BUSY, "request taken but core not busy")
   `BCRB_ASSERT(a_we_on_load, mem_we |-> rsp_load && dec_ff.kind == bcrb_pkg::KD_MEM, "register write without response")
   `BCRB_ASSERT(a_unmod_zero, rsp_valid_ff && rsp_unmod_ff |-> rsp_data_ff == 64'h0, "unmodelled access returned data")
   `BCRB_ASSERT_ALWAYS(a_reset_clear, reset |=> valid_ff == '0 && state_ff == ST_IDLE && !rsp_valid_ff, "reset left state behind")

endmodule
